// ===== hdl/c5s_pkg.sv =====
package c5s_pkg;

   // Geometry
   localparam int KERNEL_SIZE = 5;
   localparam int LINES       = KERNEL_SIZE - 1;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MAX_STRIDE  = 8;
   localparam int LINE_AW     = $clog2(MAX_WIDTH);
   localparam int LANE_W      = $clog2(LINES);

   // Field and datapath widths
   localparam int PIX_W       = 16;
   localparam int COEF_W      = 12;
   localparam int KROW_W      = KERNEL_SIZE * COEF_W;
   localparam int FW_W        = 11;
   localparam int FH_W        = 13;
   localparam int STRIDE_W    = 4;
   localparam int COL_W       = 10;
   localparam int XCOL_W      = 11;
   localparam int ROW_W       = 13;
   localparam int VALUE_W     = 18;
   localparam int OROW_W      = 12;
   localparam int OCOL_W      = 10;
   localparam int PROD_W      = PIX_W + 1 + COEF_W;
   localparam int RSUM_W      = PROD_W + 3;
   localparam int ACC_W       = RSUM_W + 2;
   localparam int MAG_W       = 32;
   localparam int QUO_W       = VALUE_W - 1;
   localparam int CSR_AW      = 3;

   // Centre offset
   localparam int HALF        = KERNEL_SIZE / 2;

   // Division of a small index by the stride: x * ceil(2^20 / s) >> 20
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 20;

   // Scaling by 1/25 then >>10, done as floor(floor(mag / 256) / 100)
   localparam int SCALE_DIV    = 25 * 1024;
   localparam int SCALE_DIV_W  = 15;
   localparam int ROUND_LIMIT  = 25;
   localparam int PRE_SHIFT    = 8;
   localparam int DIV100_RECIP = 21474837;
   localparam int DIV100_W     = 25;
   localparam int DIV100_SHIFT = 31;

   // Result queue
   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = FIFO_AW + 1;

   typedef enum logic [CSR_AW-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_STRIDE       = 3'd2,
      CSR_KERNEL_ROW_0 = 3'd3,
      CSR_KERNEL_ROW_1 = 3'd4,
      CSR_KERNEL_ROW_2 = 3'd5,
      CSR_KERNEL_ROW_3 = 3'd6,
      CSR_KERNEL_ROW_4 = 3'd7
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // One step of the window pipeline: a pixel request or a right-edge flush column
   typedef struct packed {
      logic              valid;
      logic              item;
      logic              col_zero;
      logic [LANE_W-1:0] row_lane;
      logic [LINES-1:0]  line_ok;
      pixel_type         pixel;
   } step_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [OROW_W-1:0]         out_row;
      logic [OCOL_W-1:0]         out_col;
      logic                      last;
   } result_type;

   function automatic logic [RECIP_W-1:0] stride_recip(input logic [STRIDE_W-1:0] s);
      logic [RECIP_W-1:0] r;
      unique case (s)
         4'd2:    r = 21'd524288;
         4'd3:    r = 21'd349526;
         4'd4:    r = 21'd262144;
         4'd5:    r = 21'd209716;
         4'd6:    r = 21'd174763;
         4'd7:    r = 21'd149797;
         4'd8:    r = 21'd131072;
         default: r = 21'd1048576;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/c5s_line_store.sv =====
module c5s_line_store
   import c5s_pkg::*;
(
   input  logic                   clock,
   input  logic                   access,
   input  logic [LINE_AW-1:0]     addr,
   input  logic [LANE_W-1:0]      lane,
   input  pixel_type              wdata,
   output pixel_type [LINES-1:0]  rdata
);

   // One word per column, one lane per stored row (row index mod 4)
   pixel_type [LINES-1:0] line_mem_ff [MAX_WIDTH];
   pixel_type [LINES-1:0] rdata_ff;

   // Read old column contents and overwrite the current row's lane
   always_ff @(posedge clock) begin
      if (access) begin
         line_mem_ff[addr][lane] <= wdata;
         rdata_ff                <= line_mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/c5s_conv_core.sv =====
module c5s_conv_core
   import c5s_pkg::*;
(
   input  logic                                clock,
   input  step_type                            step,
   input  pixel_type [LINES-1:0]               line_data,
   input  logic [KERNEL_SIZE-1:0][KROW_W-1:0]  kernel,
   output logic signed [VALUE_W-1:0]           value
);

   pixel_type                  window_ff [KERNEL_SIZE][KERNEL_SIZE];
   pixel_type                  window_in [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [PROD_W-1:0]   prod_ff   [KERNEL_SIZE][KERNEL_SIZE];
   logic signed [RSUM_W-1:0]   rsum_ff   [KERNEL_SIZE];
   logic signed [RSUM_W-1:0]   rsum_in   [KERNEL_SIZE];
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [ACC_W-1:0]    acc_in;
   logic [MAG_W-1:0]           mag_ff;
   logic                       neg_ff;
   logic [QUO_W-1:0]           quo_ff;
   logic [MAG_W-1:0]           mag2_ff;
   logic                       neg2_ff;
   logic [MAG_W-PRE_SHIFT-1:0] mag_hi;
   logic [MAG_W-PRE_SHIFT+DIV100_W-1:0] div_prod;
   logic [QUO_W+SCALE_DIV_W-1:0] scaled;
   logic [MAG_W-1:0]           rem;
   logic                       round_up;
   logic [VALUE_W-1:0]         mag_q;

   // Window shift: oldest row at index 0, newest column at the right
   always_comb begin
      for (int a = 0; a < KERNEL_SIZE; a++) begin
         for (int b = 0; b < KERNEL_SIZE - 1; b++) begin
            window_in[a][b] = (step.item && step.col_zero) ? '0 : window_ff[a][b+1];
         end
      end
      for (int a = 0; a < LINES; a++) begin
         window_in[a][KERNEL_SIZE-1] = (step.item && step.line_ok[a]) ?
            line_data[LANE_W'(step.row_lane + LANE_W'(a))] : '0;
      end
      window_in[KERNEL_SIZE-1][KERNEL_SIZE-1] = step.pixel;
   end

   always_ff @(posedge clock) begin
      if (step.valid) begin
         window_ff <= window_in;
      end
   end

   // Flipped-kernel products, one multiplier per tap
   always_ff @(posedge clock) begin
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            prod_ff[i][j] <= $signed(kernel[i][COEF_W*j +: COEF_W]) *
                             $signed({1'b0, window_ff[KERNEL_SIZE-1-i][KERNEL_SIZE-1-j]});
         end
      end
   end

   // Adder tree: row sums, then total
   always_comb begin
      acc_in = '0;
      for (int i = 0; i < KERNEL_SIZE; i++) begin
         rsum_in[i] = '0;
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            rsum_in[i] = rsum_in[i] + RSUM_W'(prod_ff[i][j]);
         end
         acc_in = acc_in + ACC_W'(rsum_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      rsum_ff <= rsum_in;
      acc_ff  <= acc_in;
   end

   // Sign and magnitude
   always_ff @(posedge clock) begin
      neg_ff <= acc_ff[ACC_W-1];
      mag_ff <= MAG_W'(acc_ff[ACC_W-1] ? -acc_ff : acc_ff);
   end

   // floor(mag / 25600) by reciprocal
   assign mag_hi   = mag_ff[MAG_W-1:PRE_SHIFT];
   assign div_prod = mag_hi * DIV100_W'(DIV100_RECIP);

   always_ff @(posedge clock) begin
      quo_ff  <= div_prod[DIV100_SHIFT +: QUO_W];
      mag2_ff <= mag_ff;
      neg2_ff <= neg_ff;
   end

   // Negative sums: truncated /25 then floor >>10 rounds away from zero
   // whenever the truncated quotient has a non-zero low part
   assign scaled   = quo_ff * SCALE_DIV_W'(SCALE_DIV);
   assign rem      = mag2_ff - MAG_W'(scaled);
   assign round_up = rem >= MAG_W'(ROUND_LIMIT);
   assign mag_q    = {1'b0, quo_ff} + VALUE_W'(round_up);
   assign value    = neg2_ff ? $signed(-mag_q) : $signed({1'b0, quo_ff});

endmodule

// ===== hdl/c5s_rsp_fifo.sv =====
module c5s_rsp_fifo
   import c5s_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff;
   logic                 pop;

   assign out_valid = count_ff != '0;
   assign out_data  = fifo_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + FIFO_CW'(push) - FIFO_CW'(pop);
      end
   end

endmodule

// ===== hdl/conv5x5_strided_same.sv =====
// Channel  Direction  Contents
// req_     in         tdata: pixel[15:0]; tuser: cmd[0]
// rsp_     out        tdata: value[17:0], out_row[29:18], out_col[39:30]; tlast: last
// csr_     in         index 0..7, data up to 60 bits, always ready
//
// One request per cycle. Each row from row 2 on ends with flush steps,
// with req_tready low, while two zero columns run through the window
// to produce the right-edge centres. Reset is synchronous; the line store
// is not cleared, rows above the frame are masked from the row count.
// Stalls on rsp_ are absorbed by a 16-entry result queue; req_tready drops
// when queued plus in-flight steps fill it.
module conv5x5_strided_same
   import c5s_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [PIX_W-1:0]    req_tdata,   // pixel[15:0]
   input  logic [0:0]          req_tuser,   // cmd[0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,   // value[17:0], out_row[29:18], out_col[39:30]
   output logic                rsp_tlast,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_AW-1:0]   csr_index,
   input  logic [KROW_W-1:0]   csr_data
);

   localparam int META_STAGES = 5;

   typedef struct packed {
      logic              valid;
      logic              emit;
      logic [OROW_W-1:0] out_row;
      logic [OCOL_W-1:0] out_col;
      logic              last;
   } meta_type;

   // Configuration
   logic [FW_W-1:0]                     frame_width_ff;
   logic [FH_W-1:0]                     frame_height_ff;
   logic [STRIDE_W-1:0]                 stride_ff;
   logic [KERNEL_SIZE-1:0][KROW_W-1:0]  kernel_ff;
   logic [XCOL_W-1:0]                   w_eff;
   logic [ROW_W-1:0]                    h_eff;
   logic [STRIDE_W-1:0]                 s_eff;
   logic [RECIP_W-1:0]                  recip;
   logic [ROW_W+RECIP_W-1:0]            hq_prod_ff;
   logic [XCOL_W+RECIP_W-1:0]           wq_prod_ff;
   logic [ROW_W-1:0]                    hq;
   logic [XCOL_W-1:0]                   wq;

   // Position and flush
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                row_end;
   logic [1:0]          flush_cnt_ff;
   logic [ROW_W-1:0]    flush_row_ff;
   logic [XCOL_W-1:0]   flush_col_ff;
   logic [FIFO_CW-1:0]  credit_ff;
   logic                credit_ok;
   logic                issue_item;
   logic                issue_flush;
   pixel_type           px;

   // Step stage
   step_type            step_ff;
   step_type            step_in;
   logic [ROW_W-1:0]    step_row_ff;
   logic [XCOL_W-1:0]   step_col_ff;
   pixel_type [LINES-1:0] line_data;

   // Index stage
   logic                s1_valid_ff;
   logic                s1_rok_ff;
   logic                s1_cok_ff;
   logic [ROW_W-1:0]    s1_rr_ff;
   logic [XCOL_W-1:0]   s1_cc_ff;
   logic [ROW_W+RECIP_W-1:0]  s1_rprod_ff;
   logic [XCOL_W+RECIP_W-1:0] s1_cprod_ff;
   logic [ROW_W-1:0]    rr;
   logic [XCOL_W-1:0]   cc;
   logic [ROW_W-1:0]    rq;
   logic [XCOL_W-1:0]   cq;
   logic                r_on_grid;
   logic                c_on_grid;
   meta_type            meta_ff [META_STAGES];
   meta_type            meta_in;

   logic signed [VALUE_W-1:0] value;
   logic                push;
   logic                drop;
   logic                pop;
   result_type          push_data;
   result_type          out_data;

   // Configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FW_W'(MAX_WIDTH);
         frame_height_ff <= FH_W'(1024);
         stride_ff       <= STRIDE_W'(1);
         kernel_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            CSR_STRIDE:       stride_ff       <= csr_data[STRIDE_W-1:0];
            CSR_KERNEL_ROW_0: kernel_ff[0]    <= csr_data;
            CSR_KERNEL_ROW_1: kernel_ff[1]    <= csr_data;
            CSR_KERNEL_ROW_2: kernel_ff[2]    <= csr_data;
            CSR_KERNEL_ROW_3: kernel_ff[3]    <= csr_data;
            CSR_KERNEL_ROW_4: kernel_ff[4]    <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamped settings
   always_comb begin
      if (frame_width_ff == '0)                      w_eff = XCOL_W'(1);
      else if (frame_width_ff > FW_W'(MAX_WIDTH))    w_eff = XCOL_W'(MAX_WIDTH);
      else                                           w_eff = frame_width_ff;
      if (frame_height_ff == '0)                     h_eff = ROW_W'(1);
      else if (frame_height_ff > FH_W'(MAX_HEIGHT))  h_eff = ROW_W'(MAX_HEIGHT);
      else                                           h_eff = frame_height_ff;
      if (stride_ff == '0)                           s_eff = STRIDE_W'(1);
      else if (stride_ff > STRIDE_W'(MAX_STRIDE))    s_eff = STRIDE_W'(MAX_STRIDE);
      else                                           s_eff = stride_ff;
   end

   assign recip = stride_recip(s_eff);

   // Last centre on the grid, in output units
   always_ff @(posedge clock) begin
      hq_prod_ff <= (h_eff - ROW_W'(1)) * recip;
      wq_prod_ff <= (w_eff - XCOL_W'(1)) * recip;
   end

   assign hq = hq_prod_ff[RECIP_SHIFT +: ROW_W];
   assign wq = wq_prod_ff[RECIP_SHIFT +: XCOL_W];

   // Request acceptance and flush steps
   assign credit_ok   = credit_ff < FIFO_CW'(FIFO_DEPTH);
   assign req_tready  = (flush_cnt_ff == 2'd0) && credit_ok;
   assign issue_item  = req_tvalid && req_tready;
   assign issue_flush = (flush_cnt_ff != 2'd0) && credit_ok;
   assign row_end     = XCOL_W'(col_ff) >= (w_eff - XCOL_W'(1));
   assign px          = (!req_tuser[0] && row_ff < h_eff) ? req_tdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         flush_cnt_ff <= '0;
      end else if (issue_item) begin
         if (row_end) begin
            col_ff <= '0;
            row_ff <= (row_ff >= h_eff + ROW_W'(1)) ? '0 : row_ff + ROW_W'(1);
            if (row_ff >= ROW_W'(HALF)) begin
               flush_cnt_ff <= 2'd2;
            end
         end else begin
            col_ff <= col_ff + COL_W'(1);
         end
      end else if (issue_flush) begin
         flush_cnt_ff <= flush_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_item) begin
         flush_row_ff <= row_ff;
         flush_col_ff <= XCOL_W'(col_ff) + XCOL_W'(1);
      end else if (issue_flush) begin
         flush_col_ff <= flush_col_ff + XCOL_W'(1);
      end
   end

   // Step register, aligned with the line store read
   always_comb begin
      step_in.valid    = issue_item || issue_flush;
      step_in.item     = issue_item;
      step_in.col_zero = col_ff == '0;
      step_in.row_lane = row_ff[LANE_W-1:0];
      step_in.pixel    = issue_item ? px : '0;
      for (int a = 0; a < LINES; a++) begin
         step_in.line_ok[a] = row_ff >= ROW_W'(LINES - a);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      step_row_ff <= issue_item ? row_ff : flush_row_ff;
      step_col_ff <= issue_item ? XCOL_W'(col_ff) : flush_col_ff;
   end

   c5s_line_store u_line_store (
      .clock  (clock),
      .access (issue_item),
      .addr   (col_ff),
      .lane   (row_ff[LANE_W-1:0]),
      .wdata  (px),
      .rdata  (line_data)
   );

   c5s_conv_core u_conv_core (
      .clock     (clock),
      .step      (step_ff),
      .line_data (line_data),
      .kernel    (kernel_ff),
      .value     (value)
   );

   // Centre indices and their stride quotients
   assign rr = step_row_ff - ROW_W'(HALF);
   assign cc = step_col_ff - XCOL_W'(HALF);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= step_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      s1_rok_ff   <= (step_row_ff >= ROW_W'(HALF)) && (rr < h_eff);
      s1_cok_ff   <= (step_col_ff >= XCOL_W'(HALF)) && (cc < w_eff);
      s1_rr_ff    <= rr;
      s1_cc_ff    <= cc;
      s1_rprod_ff <= rr * recip;
      s1_cprod_ff <= cc * recip;
   end

   // Grid test and output coordinates
   assign rq        = s1_rprod_ff[RECIP_SHIFT +: ROW_W];
   assign cq        = s1_cprod_ff[RECIP_SHIFT +: XCOL_W];
   assign r_on_grid = ROW_W'(rq * s_eff) == s1_rr_ff;
   assign c_on_grid = XCOL_W'(cq * s_eff) == s1_cc_ff;

   always_comb begin
      meta_in.valid   = s1_valid_ff;
      meta_in.emit    = s1_rok_ff && s1_cok_ff && r_on_grid && c_on_grid;
      meta_in.out_row = rq[OROW_W-1:0];
      meta_in.out_col = cq[OCOL_W-1:0];
      meta_in.last    = (rq == hq) && (cq == wq);
   end

   // Delay line matching the arithmetic pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < META_STAGES; k++) begin
            meta_ff[k] <= '0;
         end
      end else begin
         meta_ff[0] <= meta_in;
         for (int k = 1; k < META_STAGES; k++) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // Results into the queue
   assign push = meta_ff[META_STAGES-1].valid && meta_ff[META_STAGES-1].emit;
   assign drop = meta_ff[META_STAGES-1].valid && !meta_ff[META_STAGES-1].emit;

   always_comb begin
      push_data.value   = value;
      push_data.out_row = meta_ff[META_STAGES-1].out_row;
      push_data.out_col = meta_ff[META_STAGES-1].out_col;
      push_data.last    = meta_ff[META_STAGES-1].last;
   end

   c5s_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign pop       = rsp_tvalid && rsp_tready;
   assign rsp_tdata = {out_data.out_col, out_data.out_row, out_data.value};
   assign rsp_tlast = out_data.last;

   // Credits: steps in flight plus queued results
   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_ff + FIFO_CW'(step_in.valid) - FIFO_CW'(drop) - FIFO_CW'(pop);
      end
   end

endmodule

// ===== tb/conv5x5_strided_same_tb.sv =====
module conv5x5_strided_same_tb;
   import c5s_pkg::*;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Block ports
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PIX_W-1:0]    req_tdata  = '0;
   logic [0:0]          req_tuser  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                rsp_tlast;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [CSR_AW-1:0]   csr_index  = '0;
   logic [KROW_W-1:0]   csr_data   = '0;

   conv5x5_strided_same DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Shadow copy of the filter state and registers
   logic [FW_W-1:0]     sh_width;
   logic [FH_W-1:0]     sh_height;
   logic [STRIDE_W-1:0] sh_stride;
   logic [KROW_W-1:0]   sh_kernel [KERNEL_SIZE];
   logic [PIX_W-1:0]    sh_lines  [LINES*MAX_WIDTH];
   logic [PIX_W-1:0]    sh_win    [KERNEL_SIZE][KERNEL_SIZE];
   int                  sh_row;
   int                  sh_col;

   result_type          pending_results [$];

   int  errors        = 0;
   int  cycles        = 0;
   int  requests_sent = 0;
   int  results_seen  = 0;
   int  frames_run    = 0;
   bit  calm          = 1'b0;
   bit  hold_request  = 1'b0;
   int  hold_left     = 0;
   int  gap_left      = 0;

   // Directed stimulus table
   typedef struct {
      bit                is_csr;
      csr_index_type     idx;
      logic [KROW_W-1:0] data;
      bit                cmd;
      logic [PIX_W-1:0]  pix;
      bit                zero_out;
   } dir_row_t;

   dir_row_t dir_table [$];

   function automatic int clampi(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Flipped-kernel sum with the centre moved right by shift, scaled by 1/25 then >>10
   function automatic logic [VALUE_W-1:0] window_sum(int shift);
      longint               acc;
      longint               q;
      logic signed [COEF_W-1:0] cf;
      int                   b;
      acc = 0;
      for (int i = 0; i < KERNEL_SIZE; i++)
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            b = KERNEL_SIZE - 1 - j + shift;
            if (b <= KERNEL_SIZE - 1) begin
               cf = sh_kernel[i][COEF_W*j +: COEF_W];
               acc += longint'(cf) * longint'({1'b0, sh_win[KERNEL_SIZE-1-i][b]});
            end
         end
      q = acc / 25;
      q = q >>> 10;
      return q[VALUE_W-1:0];
   endfunction

   task automatic shadow_reset();
      sh_width  = 1024;
      sh_height = 1024;
      sh_stride = 1;
      foreach (sh_kernel[i]) sh_kernel[i] = '0;
      foreach (sh_lines[i]) sh_lines[i] = '0;
      foreach (sh_win[a, b]) sh_win[a][b] = '0;
      sh_row = 0;
      sh_col = 0;
   endtask

   task automatic shadow_write(csr_index_type idx, logic [KROW_W-1:0] data);
      case (idx)
         CSR_FRAME_WIDTH:  sh_width  = data[FW_W-1:0];
         CSR_FRAME_HEIGHT: sh_height = data[FH_W-1:0];
         CSR_STRIDE:       sh_stride = data[STRIDE_W-1:0];
         default:          sh_kernel[int'(idx) - int'(CSR_KERNEL_ROW_0)] = data;
      endcase
   endtask

   // Advance the shadow filter by one request and queue the centres it completes
   task automatic predict_centres(bit cmd, logic [PIX_W-1:0] pix);
      int w, h, s, r, c, rlast, clast, nshift, rr, cc;
      bit row_end;
      logic [PIX_W-1:0] px;
      result_type res;
      w = clampi(int'(sh_width), 1, MAX_WIDTH);
      h = clampi(int'(sh_height), 1, MAX_HEIGHT);
      s = clampi(int'(sh_stride), 1, MAX_STRIDE);
      r = sh_row;
      c = sh_col;
      rlast = ((h - 1) / s) * s;
      clast = ((w - 1) / s) * s;
      row_end = (c >= w - 1);
      px = (!cmd && r < h) ? pix : '0;

      if (c == 0)
         foreach (sh_win[a, b]) sh_win[a][b] = '0;
      for (int a = 0; a < KERNEL_SIZE; a++)
         for (int b = 0; b < KERNEL_SIZE - 1; b++)
            sh_win[a][b] = sh_win[a][b+1];
      for (int a = 0; a < LINES; a++)
         sh_win[a][KERNEL_SIZE-1] = (r + a >= LINES) ?
            sh_lines[((r + a) % LINES) * MAX_WIDTH + (c % MAX_WIDTH)] : '0;
      sh_win[KERNEL_SIZE-1][KERNEL_SIZE-1] = px;
      sh_lines[(r % LINES) * MAX_WIDTH + (c % MAX_WIDTH)] = px;

      nshift = row_end ? HALF : 0;
      if (r >= HALF) begin
         rr = r - HALF;
         if (rr < h && rr % s == 0)
            for (int k = 0; k <= nshift; k++) begin
               if (c + k < HALF) continue;
               cc = c + k - HALF;
               if (cc >= w || cc % s != 0) continue;
               res.value   = window_sum(k);
               res.out_row = OROW_W'(rr / s);
               res.out_col = OCOL_W'(cc / s);
               res.last    = (rr == rlast && cc == clast);
               pending_results.push_back(res);
            end
      end

      if (row_end) begin
         sh_col = 0;
         sh_row = (r >= h + HALF - 1) ? 0 : r + 1;
      end else begin
         sh_col = c + 1;
      end
   endtask

   // Offer one request, hold it until taken, then maybe leave a gap
   task automatic send_request(bit cmd, logic [PIX_W-1:0] pix, bit zero_out);
      int before_n;
      req_tvalid   <= 1'b1;
      req_tuser[0] <= cmd;
      req_tdata    <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      before_n = pending_results.size();
      predict_centres(cmd, pix);
      requests_sent++;
      if (zero_out)
         for (int i = before_n; i < pending_results.size(); i++)
            if (pending_results[i].value !== '0) begin
               $error("value: expected %0d, actual %0d", 0, $signed(pending_results[i].value));
               errors++;
            end
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Let the pipeline run dry before touching the registers
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [KROW_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_write(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_csr(csr_index_type idx, logic [KROW_W-1:0] data);
      dir_row_t row;
      row = '{1'b1, idx, data, 1'b0, '0, 1'b0};
      dir_table.push_back(row);
   endtask

   task automatic add_item(bit cmd, logic [PIX_W-1:0] pix, bit zero_out);
      dir_row_t row;
      row = '{1'b0, CSR_FRAME_WIDTH, '0, cmd, pix, zero_out};
      dir_table.push_back(row);
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic logic [KROW_W-1:0] rand_kernel_row();
      logic [KROW_W-1:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0)
         for (int j = 0; j < KERNEL_SIZE; j++)
            k[COEF_W*j +: COEF_W] = $urandom_range(0, 1) ? 12'h7FF : 12'h800;
      return k;
   endfunction

   // One whole frame plus its two drain rows; noise mixes drain ticks into
   // the image and stray pixels into the drain rows
   task automatic run_frame(int w, int h, bit noise);
      bit cmd;
      for (int r = 0; r < h + 2; r++)
         for (int c = 0; c < w; c++) begin
            if (r < h) cmd = noise && ($urandom_range(0, 15) == 0);
            else       cmd = !(noise && ($urandom_range(0, 3) == 0));
            send_request(cmd, rand_pixel(), 1'b0);
         end
      frames_run++;
   endtask

   // Result receiver: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left  <= 300;
         rsp_tready <= 1'b0;
      end else if (calm) begin
         rsp_tready <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left   <= gap_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         gap_left   <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Result checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            $error("unexpected result: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[17:0] !== want.value) begin
               $error("value: expected %0d, actual %0d", $signed(want.value),
                      $signed(rsp_tdata[17:0]));
               errors++;
            end
            if (rsp_tdata[29:18] !== want.out_row) begin
               $error("out_row: expected %0d, actual %0d", want.out_row, rsp_tdata[29:18]);
               errors++;
            end
            if (rsp_tdata[39:30] !== want.out_col) begin
               $error("out_col: expected %0d, actual %0d", want.out_col, rsp_tdata[39:30]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("conv5x5_strided_same test failed");
         $finish;
      end
   end

   // Main sequence
   initial begin
      int w, h, s, random_start;
      shadow_reset();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: 2x2 frame with the reset kernel of zeros, so every value is 0
      add_csr(CSR_FRAME_WIDTH, 2);
      add_csr(CSR_FRAME_HEIGHT, 2);
      add_item(1'b0, 16'hFFFF, 1'b1);
      add_item(1'b1, 16'h1234, 1'b1);   // drain tick inside the image
      add_item(1'b0, 16'h0000, 1'b1);
      add_item(1'b0, 16'h8000, 1'b1);
      add_item(1'b1, 16'h0000, 1'b1);
      add_item(1'b0, 16'hFFFF, 1'b1);   // pixel in the drain rows
      add_item(1'b1, 16'h0000, 1'b1);
      add_item(1'b1, 16'h0000, 1'b1);
      // Directed: 3x3 frame, stride 2, extreme coefficients
      add_csr(CSR_STRIDE, 2);
      add_csr(CSR_FRAME_WIDTH, 3);
      add_csr(CSR_FRAME_HEIGHT, 3);
      add_csr(CSR_KERNEL_ROW_0, {5{12'h7FF}});
      add_csr(CSR_KERNEL_ROW_1, {5{12'h800}});
      add_csr(CSR_KERNEL_ROW_2, 60'h000_000_400_000_000);
      add_csr(CSR_KERNEL_ROW_3, {5{12'h7FF}});
      add_csr(CSR_KERNEL_ROW_4, {12'h800, 12'h7FF, 12'h800, 12'h7FF, 12'h800});
      for (int i = 0; i < 9; i++)
         add_item(1'b0, (i % 3 == 1) ? 16'h0000 : 16'hFFFF, 1'b0);
      for (int i = 0; i < 6; i++)
         add_item(1'b1, 16'h0000, 1'b0);

      foreach (dir_table[i]) begin
         if (dir_table[i].is_csr) begin
            if (i == 0 || !dir_table[i-1].is_csr) wait_drained();
            write_csr(dir_table[i].idx, dir_table[i].data);
         end else begin
            send_request(dir_table[i].cmd, dir_table[i].pix, dir_table[i].zero_out);
         end
      end
      frames_run += 2;

      // Single-row frame, height and stride written out of range
      wait_drained();
      write_csr(CSR_FRAME_WIDTH, 60'd12);
      write_csr(CSR_FRAME_HEIGHT, 60'h0);
      write_csr(CSR_STRIDE, 60'hF);
      run_frame(12, 1, 1'b0);

      // Random frames, mostly small
      random_start = requests_sent;
      while (requests_sent - random_start < 400) begin
         wait_drained();
         w = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 12);
         h = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 8);
         s = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
         // Full-size frame under the long hold-off, so the block fills up
         if (frames_run == 5) begin
            w = 12;
            h = 8;
            s = 1;
         end
         if (frames_run != 5 && ($urandom_range(0, 9) == 0))
            write_csr(CSR_FRAME_WIDTH, 60'h0);   // clamps to one column
         else
            write_csr(CSR_FRAME_WIDTH, w);
         if (sh_width == 0) w = 1;
         write_csr(CSR_FRAME_HEIGHT, h);
         write_csr(CSR_STRIDE, s);
         for (int i = 0; i < KERNEL_SIZE; i++)
            if ($urandom_range(0, 1) == 0)
               write_csr(csr_index_type'(int'(CSR_KERNEL_ROW_0) + i), rand_kernel_row());
         if (frames_run == 5) hold_request = 1'b1;   // long result back-pressure
         if (requests_sent - random_start > 340) calm = 1'b1;
         run_frame(w, h, $urandom_range(0, 3) == 0);
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d expected results never arrived", pending_results.size());
         errors++;
      end
      $display("Ran %0d requests over %0d frames, %0d results checked,",
               requests_sent, frames_run, results_seen);
      $display("widths 1 to %0d, strides 1 to %0d, with noise and stalls on both sides",
               12, MAX_STRIDE);
      if (errors == 0)
         $display("conv5x5_strided_same test passed");
      else
         $display("conv5x5_strided_same test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/c5s_pkg.sv
hdl/c5s_line_store.sv
hdl/c5s_conv_core.sv
hdl/c5s_rsp_fifo.sv
hdl/conv5x5_strided_same.sv
tb/conv5x5_strided_same_tb.sv
